[rtl/core/mts_pkg.sv]
`default_nettype none
package mts_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 64;
  localparam int VALUE_W     = 16;
  localparam int ENTRY_W     = VALUE_W + 2;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // Operation codes (code 3 behaves as a read)
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [VALUE_W-1:0] push_value;
  } request_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] top_value;
    logic signed [VALUE_W-1:0] min_value;
    logic [CNT_W-1:0]          occupancy;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic fetch;
    logic capture;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_fetch;
  } dp_status_t;

endpackage
`default_nettype wire

[rtl/core/min_tracking_stack.sv]
// Each transaction steps through EXEC and RESP, with FETCH between them for a pop that
// leaves entries behind (the new top is refetched through the RAM's registered read).
// done is registered from RESP; start is ignored while busy, taken again while done shows.
// The receiver cannot stall: each result is presented for exactly one cycle.
// Reset (rst, synchronous): stack empty, minimum zero, controller idle.
`default_nettype none
module min_tracking_stack (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output      logic              busy,
  input  wire mts_pkg::request_t request,
  output      logic              done,
  output      mts_pkg::result_t  result
);

  mts_pkg::ctrl_cmd_t  cmd;
  mts_pkg::dp_status_t dp_status;

  mts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dp_status(dp_status),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  mts_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .cmd      (cmd),
    .dp_status(dp_status),
    .result   (result)
  );

endmodule
`default_nettype wire

[rtl/core/mts_ram.sv]
`default_nettype none
module mts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/mts_ctrl.sv]
`default_nettype none
module mts_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire mts_pkg::dp_status_t dp_status,
  output      mts_pkg::ctrl_cmd_t  cmd,
  output      logic               busy,
  output      logic               done
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_FETCH = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t state, state_next;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_EXEC;
      S_EXEC:  state_next = dp_status.need_fetch ? S_FETCH : S_RESP;
      S_FETCH: state_next = S_RESP;
      S_RESP:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_RESP);
    end
  end

  // Datapath commands
  assign busy        = (state != S_IDLE);
  assign cmd.load    = (state == S_IDLE) && start;
  assign cmd.exec    = (state == S_EXEC);
  assign cmd.fetch   = (state == S_FETCH);
  assign cmd.capture = (state == S_RESP);

endmodule
`default_nettype wire

[rtl/core/mts_datapath.sv]
`default_nettype none
module mts_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mts_pkg::request_t   request,
  input  wire mts_pkg::ctrl_cmd_t  cmd,
  output      mts_pkg::dp_status_t dp_status,
  output      mts_pkg::result_t    result
);

  localparam int VW = mts_pkg::VALUE_W;
  localparam int EW = mts_pkg::ENTRY_W;
  localparam int CW = mts_pkg::CNT_W;
  localparam int AW = mts_pkg::ADDR_W;

  mts_pkg::request_t     req;
  logic [CW-1:0]         fill;
  logic signed [VW-1:0]  cur_min;
  logic signed [EW-1:0]  top_entry;   // copy of the entry at fill-1
  logic [1:0]            status;

  logic                  is_push, is_pop, is_full, is_empty;
  logic signed [EW-1:0]  e_ext, m_ext, enc, restore;
  logic                  e_lt_m, y_lt_m, push_raw;
  logic                  ram_we, ram_re;
  logic [EW-1:0]         ram_wdata, ram_rdata;
  logic [CW-1:0]         rd_index;
  mts_pkg::result_t      report;

  // Decode and arithmetic on the latched transaction
  assign is_push  = (req.op == mts_pkg::OP_PUSH);
  assign is_pop   = (req.op == mts_pkg::OP_POP);
  assign is_full  = (fill == CW'(mts_pkg::STACK_DEPTH));
  assign is_empty = (fill == '0);

  assign e_ext    = {{2{req.push_value[VW-1]}}, req.push_value};
  assign m_ext    = {{2{cur_min[VW-1]}}, cur_min};
  assign enc      = (e_ext <<< 1) - m_ext;
  assign restore  = (m_ext <<< 1) - top_entry;
  assign e_lt_m   = (req.push_value < cur_min);
  assign y_lt_m   = (top_entry < m_ext);
  assign push_raw = is_empty || !e_lt_m;

  // Stack store: write on push, refetch new top after a pop
  assign ram_we    = cmd.exec && is_push && !is_full;
  assign ram_wdata = push_raw ? e_ext : enc;
  assign rd_index  = fill - CW'(2);
  assign ram_re    = cmd.exec && dp_status.need_fetch;

  assign dp_status.need_fetch = is_pop && (fill > CW'(1));

  mts_ram #(
    .WIDTH(EW),
    .DEPTH(mts_pkg::STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill[AW-1:0]),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(rd_index[AW-1:0]),
    .rdata(ram_rdata)
  );

  // Control state: occupancy and minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      cur_min <= '0;
    end else if (cmd.exec) begin
      if (is_push) begin
        if (!is_full) begin
          fill <= fill + CW'(1);
          if (push_raw && !is_empty) begin
            cur_min <= cur_min;
          end else begin
            cur_min <= req.push_value;
          end
        end
      end else if (is_pop && !is_empty) begin
        fill <= fill - CW'(1);
        if (y_lt_m) begin
          cur_min <= restore[VW-1:0];
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= request;
    end
    if (cmd.exec) begin
      if (ram_we) begin
        top_entry <= ram_wdata;
      end
      if (is_push) begin
        status <= is_full ? mts_pkg::ST_FULL : mts_pkg::ST_OK;
      end else begin
        status <= is_empty ? mts_pkg::ST_EMPTY : mts_pkg::ST_OK;
      end
    end
    if (cmd.fetch) begin
      top_entry <= ram_rdata;
    end
    if (cmd.capture) begin
      result <= report;
    end
  end

  // Result assembly from the post-operation state
  always_comb begin
    report.status    = status;
    report.occupancy = fill;
    if (is_empty) begin
      report.top_value = '0;
      report.min_value = '0;
    end else begin
      report.top_value = y_lt_m ? cur_min : top_entry[VW-1:0];
      report.min_value = cur_min;
    end
  end

endmodule
`default_nettype wire

[rtl/core/mts_checker.sv]
`default_nettype none
module mts_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire mts_pkg::result_t  result
);

  // A result is only shown while the block is free for a new transaction
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");

  // An accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accept did not raise busy");

  // An empty stack reports zero top and minimum
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.occupancy == '0) |-> (result.top_value == '0 && result.min_value == '0))
    else $error("empty stack reported nonzero values");

  // A refused push happens only at full depth
  a_full_depth: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == mts_pkg::ST_FULL) |->
      (result.occupancy == mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH)))
    else $error("full status below depth");

  // Top never lies below the minimum
  a_top_ge_min: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.top_value >= result.min_value)) else $error("top below minimum");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);
`default_nettype wire
